>>> rtl/rdf_pkg.sv
// Shared types and constants for the recent duplicate filter.
package rdf_pkg;

  localparam int WINDOW_DEPTH_DEF = 16;
  localparam int WINDOW_SIZE_RESET = 8;
  localparam logic [1:0] MIN_LEVEL_RESET = 2'd1;

  localparam int HASH_W = 64;
  localparam int LEVEL_W = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_SIZE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_LEVEL = 2'd1;

  typedef enum logic [1:0] {
    VERDICT_FORWARD = 2'd0,
    VERDICT_REJECT  = 2'd1,
    VERDICT_REPEAT  = 2'd2
  } verdict_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_WRITE,
    S_DONE
  } rdf_state_t;

  // controller -> datapath
  typedef struct packed {
    logic     load_item;
    logic     start_scan;
    logic     scan;
    logic     write_entry;
    logic     set_verdict;
    verdict_t verdict;
  } rdf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic below_level;
    logic filter_off;
    logic ring_empty;
    logic hit;
    logic scan_done;
  } rdf_status_t;

endpackage

>>> rtl/rdf_ctrl.sv
// Controller state machine of the recent duplicate filter.
module rdf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  rdf_pkg::rdf_status_t status,
  output rdf_pkg::rdf_cmd_t    cmd
);
  import rdf_pkg::*;

  rdf_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.verdict = VERDICT_FORWARD;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.below_level) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict = VERDICT_REJECT;
          state_next = S_DONE;
        end else if (status.filter_off) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict = VERDICT_FORWARD;
          state_next = S_DONE;
        end else if (status.ring_empty) begin
          state_next = S_WRITE;
        end else begin
          cmd.start_scan = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        // a hit on the last compare wins over the end of the walk
        if (status.hit) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict = VERDICT_REPEAT;
          state_next = S_DONE;
        end else if (status.scan_done) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.write_entry = 1'b1;
        cmd.set_verdict = 1'b1;
        cmd.verdict = VERDICT_FORWARD;
        state_next = S_DONE;
      end
      S_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/rdf_datapath.sv
// Datapath of the recent duplicate filter: config, hash ring, compare walk.
module rdf_datapath #(
  parameter int WINDOW_DEPTH = rdf_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [rdf_pkg::HASH_W-1:0]       msg_hash,
  input  logic [rdf_pkg::LEVEL_W-1:0]      severity,
  input  logic                             cfg_valid,
  input  logic [rdf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [rdf_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  rdf_pkg::rdf_cmd_t                cmd,
  output rdf_pkg::rdf_status_t             status,
  output logic [1:0]                       verdict
);
  import rdf_pkg::*;

  localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int CAP_RESET =
    (WINDOW_SIZE_RESET > WINDOW_DEPTH) ? WINDOW_DEPTH : WINDOW_SIZE_RESET;

  logic [HASH_W-1:0]  hash_q;
  logic [LEVEL_W-1:0] sev_q;
  logic [CNT_W-1:0]   cap;
  logic [LEVEL_W-1:0] min_level;
  logic [CNT_W-1:0]   fill_count;
  logic [PTR_W-1:0]   oldest_ptr;
  logic [PTR_W-1:0]   next_ptr;
  logic [CNT_W-1:0]   issue_cnt;
  logic [PTR_W-1:0]   rd_slot;
  logic               cmp_valid;
  logic               cmp_last;
  logic [HASH_W-1:0]  rdata;
  logic [HASH_W-1:0]  ring [WINDOW_DEPTH];
  verdict_t           verdict_q;

  logic               cfg_wr;
  logic               rd_en;
  logic [CNT_W-1:0]   cap_wr;
  logic [PTR_W-1:0]   rd_slot_next;
  logic [PTR_W-1:0]   next_ptr_next;

  assign cfg_wr = cfg_valid;
  assign rd_en  = cmd.scan && (issue_cnt != fill_count);

  // window_size saturates at the ring depth
  assign cap_wr = (32'(cfg_data) > 32'(WINDOW_DEPTH)) ? CNT_W'(WINDOW_DEPTH)
                                                      : CNT_W'(cfg_data);

  assign rd_slot_next  = ((CNT_W'(rd_slot) + 1'b1) == cap) ? '0 : rd_slot + 1'b1;
  assign next_ptr_next = ((CNT_W'(next_ptr) + 1'b1) == cap) ? '0 : next_ptr + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      hash_q <= msg_hash;
      sev_q  <= severity;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap        <= CNT_W'(CAP_RESET);
      min_level  <= MIN_LEVEL_RESET;
      fill_count <= '0;
      oldest_ptr <= '0;
      next_ptr   <= '0;
    end else if (cfg_wr) begin
      if (cfg_index == CFG_WINDOW_SIZE) begin
        cap        <= cap_wr;
        fill_count <= '0;
        oldest_ptr <= '0;
        next_ptr   <= '0;
      end else if (cfg_index == CFG_MIN_LEVEL) begin
        min_level <= cfg_data[LEVEL_W-1:0];
      end
    end else if (cmd.write_entry) begin
      next_ptr <= next_ptr_next;
      if (fill_count < cap) begin
        fill_count <= fill_count + 1'b1;
      end else begin
        oldest_ptr <= next_ptr_next;
      end
    end
  end

  // walk from the oldest entry over fill_count slots, one read a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
    end else if (cmd.start_scan) begin
      cmp_valid <= 1'b0;
    end else begin
      cmp_valid <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_scan) begin
      issue_cnt <= '0;
      rd_slot   <= oldest_ptr;
    end else if (rd_en) begin
      issue_cnt <= issue_cnt + 1'b1;
      rd_slot   <= rd_slot_next;
      cmp_last  <= (issue_cnt + 1'b1) == fill_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= ring[rd_slot];
    end
    if (cmd.write_entry) begin
      ring[next_ptr] <= hash_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_verdict) begin
      verdict_q <= cmd.verdict;
    end
  end

  assign status.below_level = sev_q < min_level;
  assign status.filter_off  = cap == '0;
  assign status.ring_empty  = fill_count == '0;
  assign status.hit         = cmp_valid && (rdata == hash_q);
  assign status.scan_done   = cmp_valid && cmp_last;

  assign verdict = verdict_q;

endmodule

>>> rtl/recent_duplicate_filter.sv
// Top level of the recent duplicate filter: controller, datapath, checks.
// A rejected or unfiltered message gets its verdict in the check state; a first
//   message goes to the write state; else stored hashes are walked for a repeat.
// Flow: one item at a time; the next input transfer follows the output transfer.
// Reset: window_size 8, min_level 1, ring empty; ring contents are not cleared.
module recent_duplicate_filter #(
  parameter int WINDOW_DEPTH = rdf_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [rdf_pkg::HASH_W-1:0]       msg_hash,
  input  logic [rdf_pkg::LEVEL_W-1:0]      severity,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       verdict,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rdf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [rdf_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rdf_pkg::*;

  rdf_cmd_t    cmd;
  rdf_status_t status;

  assign cfg_ready = 1'b1;

  rdf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rdf_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .msg_hash  (msg_hash),
    .severity  (severity),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .verdict   (verdict)
  );

  // one item in flight: no input taken while a result is offered
  assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input ready while result pending");

  // no result in the cycle after an input transfer
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid)
    else $error("result offered too early");

  // back to idle right after the output transfer
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |=> in_ready)
    else $error("not ready after output transfer");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (verdict == VERDICT_FORWARD || verdict == VERDICT_REJECT ||
                   verdict == VERDICT_REPEAT))
    else $error("undefined verdict code");

endmodule
